[hw/rtl/rcdc_pkg.sv]
// Shared types, constants and constant tables of the Rabin content-defined chunker.
package rcdc_pkg;

  // Fixed reduction polynomial of the rolling fingerprint
  localparam logic [63:0] POLY = 64'd17349423945073011;

  // Degree of a polynomial given as a bit vector
  function automatic int poly_deg(logic [63:0] v);
    int d;
    d = -1;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) d = i;
    end
    return d;
  endfunction

  localparam int FP_W       = poly_deg(POLY);
  localparam int CNT_W      = 24;
  localparam int REG_W      = 24;
  localparam int REG_IDX_W  = 2;
  localparam int WINDOW_DEF = 64;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Register indexes of the configuration port
  localparam logic [REG_IDX_W-1:0] REG_MIN = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_AVG = 2'd2;

  // Register reset values
  localparam logic [REG_W-1:0] MIN_RST = 24'd2048;
  localparam logic [REG_W-1:0] MAX_RST = 24'd65536;
  localparam logic [REG_W-1:0] AVG_RST = 24'd8192;

  typedef enum logic [1:0] {
    CAUSE_MATCH = 2'd0,
    CAUSE_MAX   = 2'd1,
    CAUSE_EOB   = 2'd2
  } cause_t;

  typedef logic [FP_W-1:0] fp_t;
  typedef fp_t fp_tbl_t [256];

  // Live configuration seen by the rolling unit
  typedef struct packed {
    logic [REG_W-1:0] min_size;
    logic [REG_W-1:0] max_size;
    logic [REG_W-1:0] mask;
  } cfg_t;

  // Cut decision for the byte in flight
  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] length;
    cause_t           cause;
  } cut_t;

  // Multiply by x^8 and reduce modulo POLY
  function automatic fp_t mul_x8(fp_t h);
    logic [FP_W+7:0] v;
    v = {h, 8'h00};
    for (int i = FP_W + 7; i >= FP_W; i--) begin
      if (v[i]) v = v ^ ((FP_W + 8)'(POLY) << (i - FP_W));
    end
    return v[FP_W-1:0];
  endfunction

  // Low part of (b * x^deg) mod POLY; the top bits cancel against the shifted word
  function automatic fp_tbl_t build_reduce();
    fp_tbl_t t;
    for (int b = 0; b < 256; b++) begin
      t[b] = mul_x8(fp_t'(b) << (FP_W - 8));
    end
    return t;
  endfunction

  // Contribution of a byte after it has travelled the whole window
  function automatic fp_tbl_t build_slide(int win);
    fp_tbl_t t;
    fp_t     h;
    for (int b = 0; b < 256; b++) begin
      h = fp_t'(b);
      for (int i = 0; i + 1 < win; i++) begin
        h = mul_x8(h);
      end
      t[b] = h;
    end
    return t;
  endfunction

  localparam fp_tbl_t RED_TBL = build_reduce();

  // Match mask: all ones below the highest set bit of the target size
  function automatic logic [REG_W-1:0] match_mask(logic [REG_W-1:0] avg);
    logic [REG_W-1:0] s;
    s[REG_W-1] = avg[REG_W-1];
    for (int i = REG_W - 2; i >= 0; i--) begin
      s[i] = s[i+1] | avg[i];
    end
    return s >> 1;
  endfunction

endpackage

[hw/rtl/rcdc_byte_if.sv]
// Input channel: one data byte with its end-of-buffer flag.
interface rcdc_byte_if import rcdc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, data_byte, end_of_buffer, input ready);
  modport sink   (input valid, data_byte, end_of_buffer, output ready);
endinterface

[hw/rtl/rcdc_chunk_if.sv]
// Output channel: length and cause of one finished chunk.
interface rcdc_chunk_if import rcdc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] chunk_length;
  cause_t           cut_cause;

  modport source (output valid, chunk_length, cut_cause, input ready);
  modport sink   (input valid, chunk_length, cut_cause, output ready);
endinterface

[hw/rtl/rcdc_cell.sv]
// One byte cell of the window shift chain.
module rcdc_cell import rcdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       shift,
  input  logic       clear,
  input  logic [7:0] fill,
  input  logic [7:0] d,
  output logic [7:0] q
);

  // Take the neighbor's byte on each transfer, or the restart value on a cut
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= fill;
    end else if (shift) begin
      q <= clear ? fill : d;
    end
  end

endmodule

[hw/rtl/rcdc_roll.sv]
// Rolling fingerprint, byte count and cut decision.
module rcdc_roll import rcdc_pkg::*; #(
  parameter int WINDOW_BYTES = WINDOW_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_buffer,
  input  logic [7:0] old_next,
  input  cfg_t       cfg,
  output cut_t       cut
);

  localparam fp_tbl_t SLIDE_TBL = build_slide(WINDOW_BYTES);

  fp_t              fp;
  fp_t              slide;
  logic [CNT_W-1:0] count;

  fp_t              fp_slid;
  fp_t              fp_next;
  logic [7:0]       idx;
  logic [CNT_W-1:0] count_next;
  logic             match;
  logic             at_max;

  // Drop the oldest byte, shift the new one in, reduce by table
  always_comb begin
    fp_slid = fp ^ slide;
    idx     = fp_slid[FP_W-1 -: 8];
    fp_next = {fp_slid[FP_W-9:0], data_byte} ^ RED_TBL[idx];
  end

  // Saturating count and cut causes, match first
  always_comb begin
    count_next = (count == COUNT_MAX) ? count : count + 1'b1;
    match      = (count_next >= cfg.min_size) &&
                 ((fp_next[REG_W-1:0] & cfg.mask) == '0);
    at_max     = count_next >= cfg.max_size;
    cut.hit    = match || at_max || end_of_buffer;
    cut.length = count_next;
    if (match) begin
      cut.cause = CAUSE_MATCH;
    end else if (at_max) begin
      cut.cause = CAUSE_MAX;
    end else begin
      cut.cause = CAUSE_EOB;
    end
  end

  // Advance on each transfer; restart the chunk on a cut.
  // The slide-out term of the next oldest byte is looked up one byte ahead.
  always_ff @(posedge clk) begin
    if (rst) begin
      fp    <= fp_t'(1);
      count <= '0;
      slide <= '0;
    end else if (accept) begin
      if (cut.hit) begin
        fp    <= fp_t'(1);
        count <= '0;
        slide <= '0;
      end else begin
        fp    <= fp_next;
        count <= count_next;
        slide <= SLIDE_TBL[old_next];
      end
    end
  end

endmodule

[hw/rtl/rabin_content_defined_chunker.sv]
// Top level of the Rabin content-defined chunker.
//
// Bytes arrive on the data channel, one per transfer, with end_of_buffer set
// on the last byte of a buffer. For each chunk that ends, one transfer on the
// chunk channel carries its length and the cause of the cut (fingerprint
// match, maximum size, end of buffer).
// Throughput: one byte per cycle while the skid register is empty. The
// fingerprint update, two constant-table lookups and the cut compare are
// combinational; the slide-out lookup for the oldest window byte is made
// one byte ahead. Each chunk result is registered in the output or skid register.
// The window is a chain of WINDOW_BYTES byte cells that shifts on every
// transfer.
// Reset (synchronous, active high) loads the default sizes and starts an
// empty chunk. Configuration is written through wr_en/wr_index/wr_data;
// the user must do so only while no bytes are in flight (not enforced).
// When the receiver stalls, one further result is held in a skid register;
// data.ready drops only while that register is occupied.
module rabin_content_defined_chunker import rcdc_pkg::*; #(
  parameter int WINDOW_BYTES = WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  rcdc_byte_if.sink            data,
  rcdc_chunk_if.source         chunk,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data
);

  cfg_t       cfg;
  cut_t       cut;
  logic [7:0] win [WINDOW_BYTES];
  logic       accept;
  logic       push;
  logic       pop;
  logic       load_out;
  logic       load_skid;
  logic       move_skid;

  logic             out_valid;
  logic [CNT_W-1:0] out_length;
  cause_t           out_cause;
  logic             skid_valid;
  logic [CNT_W-1:0] skid_length;
  cause_t           skid_cause;

  // Configuration registers; the target size is kept as its match mask
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_size <= MIN_RST;
      cfg.max_size <= MAX_RST;
      cfg.mask     <= match_mask(AVG_RST);
    end else if (wr_en) begin
      case (wr_index)
        REG_MIN: cfg.min_size <= wr_data;
        REG_MAX: cfg.max_size <= wr_data;
        REG_AVG: cfg.mask     <= match_mask(wr_data);
        default: ;
      endcase
    end
  end

  assign data.ready = !skid_valid;
  assign accept     = data.valid && data.ready;

  // Window chain: cell 0 takes the new byte, the last cell is the oldest
  for (genvar i = 0; i < WINDOW_BYTES; i++) begin : g_cell
    if (i == 0) begin : g_head
      rcdc_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (accept),
        .clear (cut.hit),
        .fill  (8'd1),
        .d     (data.data_byte),
        .q     (win[i])
      );
    end else begin : g_body
      rcdc_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (accept),
        .clear (cut.hit),
        .fill  (8'd0),
        .d     (win[i-1]),
        .q     (win[i])
      );
    end
  end

  rcdc_roll #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_roll (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data.data_byte),
    .end_of_buffer (data.end_of_buffer),
    .old_next      (win[WINDOW_BYTES-2]),
    .cfg           (cfg),
    .cut           (cut)
  );

  // Output register and skid: route each new result
  always_comb begin
    push      = accept && cut.hit;
    pop       = out_valid && chunk.ready;
    move_skid = skid_valid && pop;
    load_skid = push && out_valid && !pop;
    load_out  = push && (!out_valid || pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (load_out || move_skid) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load_skid) begin
        skid_valid <= 1'b1;
      end else if (move_skid) begin
        skid_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (move_skid) begin
      out_length <= skid_length;
      out_cause  <= skid_cause;
    end else if (load_out) begin
      out_length <= cut.length;
      out_cause  <= cut.cause;
    end
    if (load_skid) begin
      skid_length <= cut.length;
      skid_cause  <= cut.cause;
    end
  end

  assign chunk.valid        = out_valid;
  assign chunk.chunk_length = out_length;
  assign chunk.cut_cause    = out_cause;

endmodule

[dv/tb_rabin_content_defined_chunker.sv]
// Testbench for the Rabin content-defined chunker: random byte stream checked against a predictor.
`timescale 1ns / 1ps

module tb_rabin_content_defined_chunker;
  import rcdc_pkg::*;

  localparam logic [63:0] GF_POLY   = 64'd17349423945073011;
  localparam int          FP_BITS   = 53;      // degree of GF_POLY
  localparam int          WIN_LEN   = 64;
  localparam int          IDLE_PCT  = 22;
  localparam int unsigned CYCLE_CAP = 200000;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } byte_item_t;

  typedef struct {
    logic [CNT_W-1:0] length;
    cause_t           cause;
  } chunk_rec_t;

  logic clk = 1'b0;
  logic rst;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] wr_index;
  logic [REG_W-1:0]     wr_data;

  rcdc_byte_if  data_ch ();
  rcdc_chunk_if chunk_ch ();

  rabin_content_defined_chunker i_dut (
    .clk      (clk),
    .rst      (rst),
    .data     (data_ch),
    .chunk    (chunk_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #1 clk = ~clk;

  byte_item_t  pending_bytes[$];
  chunk_rec_t  expected_chunks[$];
  int          mismatches = 0;
  int unsigned cycles = 0;
  logic        gapless = 1'b0;

  // Fingerprint state of the chunk in progress
  logic [63:0] slide_tbl [256];
  logic [63:0] red_tbl [256];
  logic [7:0]  win [WIN_LEN];
  int          wpos;
  logic [23:0] byte_cnt;
  logic [63:0] fp;
  logic [23:0] min_size;
  logic [23:0] max_size;
  logic [23:0] avg_size;

  // Reduce a polynomial of up to 64 bits modulo GF_POLY
  function automatic logic [63:0] gf_mod(logic [63:0] v);
    for (int i = 63; i >= FP_BITS; i--) begin
      if (v[i]) v = v ^ (GF_POLY << (i - FP_BITS));
    end
    return v;
  endfunction

  function automatic void build_tables();
    logic [63:0] h;
    logic [63:0] top;
    for (int b = 0; b < 256; b++) begin
      h = gf_mod(64'(b));
      for (int i = 0; i + 1 < WIN_LEN; i++) begin
        h = gf_mod(h << 8);
      end
      slide_tbl[b] = h;
      top = 64'(b) << FP_BITS;
      red_tbl[b] = gf_mod(top) | top;
    end
  endfunction

  function automatic logic [63:0] mask_for(logic [23:0] avg);
    int m;
    m = -1;
    for (int i = 0; i < 24; i++) begin
      if (avg[i]) m = i;
    end
    if (m <= 0) return 64'd0;
    return (64'd1 << m) - 64'd1;
  endfunction

  // Slide the oldest byte out, then shift the new byte in
  function automatic void roll_in(logic [7:0] b);
    logic [7:0] old;
    logic [7:0] idx;
    old = win[wpos];
    win[wpos] = b;
    fp = fp ^ slide_tbl[old];
    wpos = (wpos + 1) % WIN_LEN;
    idx = fp[FP_BITS-1 -: 8];
    fp = ((fp << 8) | 64'(b)) ^ red_tbl[idx];
  endfunction

  function automatic void restart_chunk();
    for (int i = 0; i < WIN_LEN; i++) begin
      win[i] = 8'd0;
    end
    wpos = 0;
    byte_cnt = 24'd0;
    fp = 64'd0;
    roll_in(8'd1);
  endfunction

  // Advance the fingerprint by one byte and queue the chunk it ends, if any
  function automatic void predict_cut(logic [7:0] b, logic eob);
    chunk_rec_t rec;
    logic       hit;
    roll_in(b);
    if (byte_cnt != COUNT_MAX) byte_cnt = byte_cnt + 24'd1;
    hit = 1'b1;
    if (byte_cnt >= min_size && (fp & mask_for(avg_size)) == 64'd0) rec.cause = CAUSE_MATCH;
    else if (byte_cnt >= max_size) rec.cause = CAUSE_MAX;
    else if (eob) rec.cause = CAUSE_EOB;
    else hit = 1'b0;
    if (hit) begin
      rec.length = byte_cnt;
      expected_chunks.push_back(rec);
      restart_chunk();
    end
  endfunction

  function automatic void push_byte(logic [7:0] b, logic eob);
    byte_item_t it;
    it.data = b;
    it.eob = eob;
    pending_bytes.push_back(it);
  endfunction

  // Random bytes; the last one always closes the buffer
  function automatic void queue_random(int n, int eob_pct);
    for (int i = 0; i < n; i++) begin
      push_byte(8'($urandom_range(255)), (i == n - 1) || ($urandom_range(99) < eob_pct));
    end
  endfunction

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    case (idx)
      REG_MIN: min_size = val;
      REG_MAX: max_size = val;
      REG_AVG: avg_size = val;
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic apply_config(logic [23:0] mn, logic [23:0] mx, logic [23:0] av);
    write_reg(REG_MIN, mn);
    write_reg(REG_MAX, mx);
    write_reg(REG_AVG, av);
    @(negedge clk);
  endtask

  // Wait until every byte is taken and every chunk has come out
  task automatic settle();
    while (pending_bytes.size() != 0 || data_ch.valid || expected_chunks.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // Drive the byte channel from the pending queue
  always @(posedge clk) begin
    byte_item_t it;
    if (rst) begin
      data_ch.valid <= 1'b0;
    end else if (!data_ch.valid || data_ch.ready) begin
      if (pending_bytes.size() != 0 && (gapless || $urandom_range(99) >= IDLE_PCT)) begin
        it = pending_bytes.pop_front();
        data_ch.valid         <= 1'b1;
        data_ch.data_byte     <= it.data;
        data_ch.end_of_buffer <= it.eob;
      end else begin
        data_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the chunk channel at random
  always @(posedge clk) begin
    if (rst) begin
      chunk_ch.ready <= 1'b0;
    end else begin
      chunk_ch.ready <= gapless || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Predict on each byte transfer, check each chunk transfer
  always @(posedge clk) begin
    chunk_rec_t rec;
    if (!rst) begin
      if (data_ch.valid && data_ch.ready) begin
        predict_cut(data_ch.data_byte, data_ch.end_of_buffer);
      end
      if (chunk_ch.valid && chunk_ch.ready) begin
        if (expected_chunks.size() == 0) begin
          $display("%0t: unexpected chunk: expected none, actual length %0d cause %0d",
                   $time, chunk_ch.chunk_length, chunk_ch.cut_cause);
          mismatches++;
        end else begin
          rec = expected_chunks.pop_front();
          if (chunk_ch.chunk_length !== rec.length) begin
            $display("%0t: chunk_length mismatch: expected %0d, actual %0d",
                     $time, rec.length, chunk_ch.chunk_length);
            mismatches++;
          end
          if (chunk_ch.cut_cause !== rec.cause) begin
            $display("%0t: cut_cause mismatch: expected %0d, actual %0d",
                     $time, rec.cause, chunk_ch.cut_cause);
            mismatches++;
          end
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [23:0] mn;
    logic [23:0] mx;
    logic [23:0] av;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = REG_MIN;
    wr_data = '0;
    data_ch.valid = 1'b0;
    data_ch.data_byte = 8'd0;
    data_ch.end_of_buffer = 1'b0;
    chunk_ch.ready = 1'b0;
    build_tables();
    min_size = MIN_RST;
    max_size = MAX_RST;
    avg_size = AVG_RST;
    restart_chunk();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset sizes: short buffers end on the flag alone
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b1);
    queue_random(4, 0);
    settle();

    // Empty mask with minimum one: every byte matches, even on a buffer end
    apply_config(24'd1, COUNT_MAX, 24'd0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h80, 1'b0);
    settle();
    apply_config(24'd1, COUNT_MAX, 24'd1);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h01, 1'b1);
    settle();

    // Unreachable match: maximum wins over the buffer end
    apply_config(COUNT_MAX, 24'd3, COUNT_MAX);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b1);
    push_byte(8'h78, 1'b0);
    push_byte(8'h9A, 1'b1);
    queue_random(3, 0);
    settle();

    // Zero minimum and zero maximum: every byte cuts alone
    apply_config(24'd0, 24'd0, COUNT_MAX);
    push_byte(8'hC3, 1'b0);
    push_byte(8'h3C, 1'b1);
    settle();

    // All three causes at once: the match wins
    apply_config(24'd0, 24'd0, 24'd0);
    push_byte(8'hE7, 1'b1);
    settle();

    // Random sizes with random content
    for (int p = 0; p < 8; p++) begin
      gapless = (p == 3);
      mn = 24'($urandom_range(0, 40));
      mx = 24'($urandom_range(1, 150));
      av = 24'($urandom_range(1, 255));
      if (p == 5) begin
        mx = COUNT_MAX;
        av = 24'($urandom_range(24'h800000, COUNT_MAX));
      end
      apply_config(mn, mx, av);
      queue_random(85, (p == 5) ? 6 : 3);
      settle();
    end
    gapless = 1'b0;

    repeat (8) @(negedge clk);
    if (mismatches == 0 && expected_chunks.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
